// File: hdl/wpfd_pkg.sv
// Shared types and constants for the windowed peak frame detector.
// Used by every module under hdl/; depends on nothing else.
package wpfd_pkg;

  // Field widths
  localparam int SCORE_W = 32;
  localparam int CH_W    = 4;
  localparam int CNT_W   = 21;
  localparam int TWIN_W  = CNT_W + 1;
  localparam int OUT_W   = 80;

  // Frequency channels per chip; a chip also ends at the widest 4-bit index
  localparam int CHANNELS = 16;
  localparam logic [CH_W-1:0] POS_LAST =
    (CHANNELS > 16) ? 4'd15 : CH_W'(CHANNELS - 1);

  // Window limits and reset value
  localparam logic [CNT_W-1:0] WIN_MAX   = 21'd1048576;
  localparam logic [CNT_W-1:0] WIN_MIN   = 21'd1;
  localparam logic [CNT_W-1:0] WIN_RESET = 21'd1024;

  // Remainder sweep length, one dividend bit per cycle
  localparam logic [4:0] RED_LAST = 5'(CNT_W - 1);

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  // One detection result
  typedef struct packed {
    logic                frame_active;
    logic                peak_settled;
    logic [SCORE_W-1:0]  peak_score;
    logic [CH_W-1:0]     peak_channel;
    logic [CNT_W-1:0]    chips_since_peak;
    logic [CNT_W-1:0]    chips_since_detect;
  } wpfd_result_t;

  // Status of the count reduction unit
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              big;
    logic [CNT_W-1:0]  rem;
  } wpfd_red_t;

endpackage

// File: hdl/wpfd_rem.sv
// Iterative remainder unit: reduces the detection count modulo twice the window.
// One dividend bit per cycle, restoring form. Depends on wpfd_pkg.
module wpfd_rem
  import wpfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  dividend,
  input  logic [TWIN_W-1:0] divisor,
  output wpfd_red_t         status
);

  logic              busy;
  logic [4:0]        cnt;
  logic [CNT_W-1:0]  d_sh;
  logic [CNT_W-1:0]  r;
  logic [TWIN_W-1:0] div_q;
  logic              big;

  logic [TWIN_W-1:0] trial;
  logic              ge;
  logic [TWIN_W-1:0] diff;
  logic [CNT_W-1:0]  r_next;
  logic              done;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial  = {r, d_sh[CNT_W-1]};
    ge     = trial >= div_q;
    diff   = trial - div_q;
    r_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    done   = busy && (cnt == RED_LAST);
  end

  // Sequence the sweep; a new start restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= !done;
      cnt  <= cnt + 5'd1;
    end
  end

  // Datapath of the sweep
  always_ff @(posedge clk) begin
    if (start) begin
      d_sh  <= dividend;
      r     <= '0;
      div_q <= divisor;
      big   <= {1'b0, dividend} >= divisor;
    end else if (busy) begin
      d_sh <= {d_sh[CNT_W-2:0], 1'b0};
      r    <= r_next;
    end
  end

  assign status = '{busy: busy, done: done, big: big, rem: r_next};

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("remainder unit did not start");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && !done && !start) |=> busy)
    else $error("remainder unit stopped early");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, r_next} < div_q))
    else $error("remainder not below divisor");

endmodule

// File: hdl/wpfd_track.sv
// Per-chip argmax tracking and the once-per-chip detection rule with its state.
// Depends on wpfd_pkg; the count reload comes from wpfd_rem.
module wpfd_track
  import wpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [SCORE_W-1:0] score_value,
  input  logic               last_channel,
  input  logic [SCORE_W-1:0] threshold,
  input  logic [CNT_W-1:0]   win,
  input  logic [TWIN_W-1:0]  twin,
  input  wpfd_red_t          red,
  output logic               chip_end,
  output logic [CNT_W-1:0]   detect_count,
  output wpfd_result_t       result
);

  // Chip and detection state
  logic [CH_W-1:0]    channel_pos;
  logic [SCORE_W-1:0] chip_max;
  logic [CH_W-1:0]    chip_argmax;
  logic               frame_seen;
  logic [SCORE_W-1:0] best_score;
  logic [CH_W-1:0]    best_channel;
  logic [CNT_W-1:0]   peak_count;
  // Reduced copy of the count, kept below twice the current window
  logic [CNT_W-1:0]   work_count;
  logic               count_big;

  logic               take_new;
  logic [SCORE_W-1:0] cand_max;
  logic [CH_W-1:0]    cand_arg;
  logic [TWIN_W-1:0]  count;
  logic               reach_twin;
  logic               settled_win;
  logic               relaxed;
  logic               higher;
  logic               over;
  logic               fetch;
  logic [CNT_W-1:0]   count_wrap;
  logic               frame_seen_next;
  logic [SCORE_W-1:0] best_score_next;
  logic [CH_W-1:0]    best_channel_next;
  logic [CNT_W-1:0]   peak_count_next;
  logic [CNT_W-1:0]   detect_count_next;

  // Running argmax, ties kept at the lowest channel
  always_comb begin
    take_new = (channel_pos == '0) || (score_value > chip_max);
    cand_max = take_new ? score_value : chip_max;
    cand_arg = take_new ? channel_pos : chip_argmax;
    chip_end = last_channel || (channel_pos == POS_LAST);
  end

  // Detection rule; the working count stays below twice the window
  always_comb begin
    count       = {1'b0, work_count} + TWIN_W'(1);
    reach_twin  = count == twin;
    settled_win = count_big || (count >= {1'b0, win});
    relaxed     = count_big || reach_twin;
    higher      = best_score < cand_max;
    over        = cand_max > threshold;
    fetch       = !(frame_seen && !relaxed) || (higher && !settled_win && !relaxed);
    count_wrap  = reach_twin ? '0 : count[CNT_W-1:0];

    frame_seen_next   = (frame_seen && !relaxed) || over;
    best_score_next   = fetch ? cand_max : best_score;
    best_channel_next = fetch ? cand_arg : best_channel;
    peak_count_next   = fetch ? count_wrap : peak_count;
    detect_count_next = frame_seen ? count_wrap : '0;

    result.frame_active       = frame_seen_next;
    result.peak_settled       = settled_win && !relaxed && frame_seen;
    result.peak_score         = best_score_next;
    result.peak_channel       = best_channel_next;
    result.chips_since_peak   = peak_count_next;
    result.chips_since_detect = detect_count_next;
  end

  // Advance chip and detection state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_pos  <= '0;
      chip_max     <= '0;
      chip_argmax  <= '0;
      frame_seen   <= 1'b0;
      best_score   <= '0;
      best_channel <= '0;
      peak_count   <= '0;
      detect_count <= '0;
      work_count   <= '0;
      count_big    <= 1'b0;
    end else if (red.done) begin
      work_count <= red.rem;
      count_big  <= red.big;
    end else if (fire) begin
      if (chip_end) begin
        channel_pos  <= '0;
        chip_max     <= '0;
        chip_argmax  <= '0;
        frame_seen   <= frame_seen_next;
        best_score   <= best_score_next;
        best_channel <= best_channel_next;
        peak_count   <= peak_count_next;
        detect_count <= detect_count_next;
        work_count   <= detect_count_next;
        count_big    <= 1'b0;
      end else begin
        channel_pos <= channel_pos + CH_W'(1);
        chip_max    <= cand_max;
        chip_argmax <= cand_arg;
      end
    end
  end

endmodule

// File: hdl/windowed_peak_frame_detector_core.sv
// Top level of the windowed peak frame detector: stream ports, config registers,
// input and result registers. Depends on wpfd_pkg, wpfd_rem and wpfd_track.
//
// Usage: one 32-bit unsigned score per request on the s_ side, one per frequency
// channel of a chip, with s_tlast on the chip's last channel (a chip also ends
// after the sixteenth channel). Each chip end yields one result request on the
// m_ side; other requests yield nothing.
// Throughput: one request per cycle, set by the single compare-and-update stage,
// while no count reduction or waiting chip end holds s_tready low. A chip-end
// request passes the input register, then the result register, where m_ can take
// it. A write to window_length starts a count reduction (one bit a cycle through
// the remainder unit) during which s_tready stays low. Configuration is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while idle,
// which the block does not enforce. Reset clears all detection state, threshold
// to 0 and window_length to 1024. When m_tready is low, a pending result holds in
// the output register; the input register keeps taking channels that do not end
// a chip, and a chip end waits there until the output register frees.
module windowed_peak_frame_detector_core
  import wpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // score input
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // [31:0] score_value
  input  logic               s_tlast,   // last_channel
  // detection result
  output logic               m_tvalid,
  input  logic               m_tready,
  // [0] frame_active, [1] peak_settled, [33:2] peak_score,
  // [37:34] peak_channel, [58:38] chips_since_peak, [79:59] chips_since_detect
  output logic [OUT_W-1:0]   m_tdata,
  // configuration write
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [SCORE_W-1:0] detect_threshold;
  logic [CNT_W-1:0]   window_length;
  logic               start_pending;
  logic [CNT_W-1:0]   win;
  logic [TWIN_W-1:0]  twin;

  logic               in_valid;
  logic [SCORE_W-1:0] in_score;
  logic               in_last;
  logic               s2_fire;
  logic               chip_end;
  logic [CNT_W-1:0]   detect_count;
  wpfd_result_t       result;
  wpfd_red_t          red;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold <= '0;
      window_length    <= WIN_RESET;
      start_pending    <= 1'b0;
    end else begin
      start_pending <= cfg_we && (cfg_index == REG_WINDOW);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: detect_threshold <= cfg_data;
          REG_WINDOW:    window_length    <= cfg_data[CNT_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // Clamp the window into its legal range
  always_comb begin
    priority if (window_length == '0) win = WIN_MIN;
    else if (window_length > WIN_MAX) win = WIN_MAX;
    else win = window_length;
    twin = {win, 1'b0};
  end

  // Handshake: a chip end waits for room in the result register
  assign s2_fire  = in_valid && (!chip_end || !m_tvalid || m_tready);
  assign s_tready = !red.busy && !start_pending && (!in_valid || s2_fire);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end else if (s2_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_score <= s_tdata;
      in_last  <= s_tlast;
    end
  end

  wpfd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (start_pending),
    .dividend (detect_count),
    .divisor  (twin),
    .status   (red)
  );

  wpfd_track u_track (
    .clk          (clk),
    .rst          (rst),
    .fire         (s2_fire),
    .score_value  (in_score),
    .last_channel (in_last),
    .threshold    (detect_threshold),
    .win          (win),
    .twin         (twin),
    .red          (red),
    .chip_end     (chip_end),
    .detect_count (detect_count),
    .result       (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_fire && chip_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && chip_end) begin
      m_tdata <= {result.chips_since_detect, result.chips_since_peak,
                  result.peak_channel, result.peak_score,
                  result.peak_settled, result.frame_active};
    end
  end

  a_no_take_reducing: assert property (@(posedge clk) disable iff (rst)
    red.busy |-> !s_tready)
    else $error("request taken during count reduction");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  a_settled_detected: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("peak settled without an active detection");

endmodule
